FILE: rtl/pulse_beat_counter_core_defines.svh
// Assertion macros shared by the pulse beat counter RTL.
`ifndef PULSE_BEAT_COUNTER_CORE_DEFINES_SVH
`define PULSE_BEAT_COUNTER_CORE_DEFINES_SVH

// Checked on every rising edge of i_clk while the block is out of reset.
`define PBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, reset cycles included.
`define PBC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/pbc_pkg.sv
// Shared types and constants of the pulse beat counter.
package pbc_pkg;

    localparam int IDX_W   = 5;
    localparam int VAL_W   = 10;
    localparam int HEART_W = 11;
    localparam int ADD_W   = 2;
    localparam int COUNT_W = 16;
    localparam int THR_W   = 11;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - HEART_W - ADD_W - COUNT_W;

    localparam logic signed [THR_W-1:0]   THR_RESET     = 11'sd3;
    localparam logic signed [HEART_W-1:0] ARM_BELOW_LVL = -11'sd2;
    localparam logic signed [HEART_W-1:0] FIRE_BELOW_LVL = 11'sd0;

    // One input word as it sits in the first pipeline register.
    typedef struct packed {
        logic [IDX_W-1:0] slot;
        logic [VAL_W-1:0] value;
        logic             clear;
    } t_item;

endpackage

FILE: rtl/pbc_window.sv
// Sample window memory, running window sum and window mean.
`include "pulse_beat_counter_core_defines.svh"

module pbc_window #(
    parameter int WINDOW_SIZE = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [pbc_pkg::IDX_W-1:0]   i_rd_slot,
    input  logic                        i_adv,
    input  pbc_pkg::t_item              i_s1,
    output logic [pbc_pkg::VAL_W-1:0]   o_mean
);

    localparam int AW      = $clog2(WINDOW_SIZE);
    localparam int SUM_MAX = WINDOW_SIZE * 1023;
    localparam int SW      = $clog2(SUM_MAX + 1);
    // Floor division by the window size as a multiply by a rounded-up
    // reciprocal; exact for every sum of SW bits.
    localparam int SHIFT   = SW + AW;
    localparam int MULT    = ((2 ** SHIFT) + WINDOW_SIZE - 1) / WINDOW_SIZE;
    localparam int MW      = SW + 1;
    localparam int PW      = SW + MW;

    logic [pbc_pkg::VAL_W-1:0] r_mem [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0]    r_wvld;
    logic [pbc_pkg::VAL_W-1:0] r_rd_data;
    logic                      r_rd_vld;
    logic                      r_lw_vld;
    logic [AW-1:0]             r_lw_addr;
    logic [pbc_pkg::VAL_W-1:0] r_lw_data;
    logic [SW-1:0]             r_sum;
    logic [SW-1:0]             n_sum;

    logic                      rd_in_range;
    logic [AW-1:0]             rd_addr;
    logic                      s1_in_range;
    logic [AW-1:0]             s1_addr;
    logic [pbc_pkg::VAL_W-1:0] old_val;
    logic [PW-1:0]             prod;

    assign rd_in_range = 32'(i_rd_slot) < WINDOW_SIZE;
    assign rd_addr     = AW'(i_rd_slot);
    assign s1_in_range = 32'(i_s1.slot) < WINDOW_SIZE;
    assign s1_addr     = AW'(i_s1.slot);

    // The read for a word happens when it is taken in; a write of the word
    // ahead of it may land at that same edge, so the last write is forwarded.
    always_comb begin
        if (r_lw_vld && (r_lw_addr == s1_addr)) begin
            old_val = r_lw_data;
        end else if (r_rd_vld) begin
            old_val = r_rd_data;
        end else begin
            old_val = '0;
        end
    end

    always_comb begin
        if (s1_in_range) begin
            n_sum = r_sum - SW'(old_val) + SW'(i_s1.value);
        end else begin
            n_sum = r_sum;
        end
    end

    assign prod   = PW'(n_sum) * PW'(MULT);
    assign o_mean = pbc_pkg::VAL_W'(prod >> SHIFT);

    always_ff @(posedge i_clk) begin
        if (i_adv && s1_in_range) begin
            r_mem[s1_addr] <= i_s1.value;
        end
        if (i_rd_en && rd_in_range) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_adv) begin
            r_lw_addr <= s1_addr;
            r_lw_data <= i_s1.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld   <= '0;
            r_rd_vld <= 1'b0;
            r_lw_vld <= 1'b0;
            r_sum    <= '0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= rd_in_range && r_wvld[rd_addr];
            end
            if (i_adv) begin
                r_lw_vld <= s1_in_range;
                r_sum    <= n_sum;
                if (s1_in_range) begin
                    r_wvld[s1_addr] <= 1'b1;
                end
            end
        end
    end

    `PBC_ASSERT(a_sum_bound, r_sum <= SW'(SUM_MAX), "window sum exceeds full-scale window")

endmodule

FILE: rtl/pbc_detect.sv
// Crossing detectors and the saturating beat count.
`include "pulse_beat_counter_core_defines.svh"

module pbc_detect (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic signed [pbc_pkg::HEART_W-1:0]  i_heart,
    input  logic                                i_clear,
    input  logic signed [pbc_pkg::THR_W-1:0]    i_threshold,
    output logic [pbc_pkg::ADD_W-1:0]           o_added,
    output logic [pbc_pkg::COUNT_W-1:0]         o_total
);

    logic                          r_armed_above;
    logic                          r_armed_below;
    logic [pbc_pkg::COUNT_W-1:0]   r_count;

    logic                          arm_a;
    logic                          hit_a;
    logic                          arm_b;
    logic                          hit_b;
    logic [pbc_pkg::COUNT_W-1:0]   base;
    logic [pbc_pkg::COUNT_W:0]     grown;

    assign arm_a = r_armed_above || (i_heart > i_threshold);
    assign hit_a = arm_a && (i_heart < i_threshold);
    assign arm_b = r_armed_below || (i_heart < pbc_pkg::ARM_BELOW_LVL);
    assign hit_b = arm_b && (i_heart > pbc_pkg::FIRE_BELOW_LVL);

    assign o_added = pbc_pkg::ADD_W'(hit_a) + pbc_pkg::ADD_W'(hit_b);

    // Clearing comes first, then both increments, stopping at full scale.
    assign base    = i_clear ? '0 : r_count;
    assign grown   = {1'b0, base} + (pbc_pkg::COUNT_W + 1)'(o_added);
    assign o_total = grown[pbc_pkg::COUNT_W] ? '1 : grown[pbc_pkg::COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed_above <= 1'b0;
            r_armed_below <= 1'b0;
            r_count       <= '0;
        end else if (i_adv) begin
            r_armed_above <= arm_a && !hit_a;
            r_armed_below <= arm_b && !hit_b;
            r_count       <= o_total;
        end
    end

    `PBC_ASSERT(a_count_monotone, (i_adv && !i_clear) |=> (r_count >= $past(r_count)), "beat count fell without a clear")

endmodule

FILE: rtl/pulse_beat_counter_core.sv
// Top level of the pulse beat counter: ports, pipeline registers, heart value.
//
//  Channel   Direction  Payload                                   Handshake
//  s_axis    in         tdata: sample_index, sample_value         tvalid/tready
//                       tuser: clear_count
//  m_axis    out        tdata: heart_value, beats_added,          tvalid/tready
//                       beat_total
//  cfg       in         beat_threshold                            write enable
//
// A word is taken into the first pipeline register, where the window slot is
// read from the sample memory, and its result is formed from that register
// and held in the output register when the word moves on; one word per cycle
// is sustained while the output is taken, set by the single read and write
// port of the sample memory and the update of the running window sum.
// Reset is synchronous and active low; it empties both pipeline registers,
// clears the window sum, the detector flags and the beat count, marks every
// window slot as holding zero and sets the threshold to 3.
// While the output word is not taken the first register holds its word, and
// a new word is refused only when both registers are full.
`include "pulse_beat_counter_core_defines.svh"

module pulse_beat_counter_core #(
    parameter int WINDOW_SIZE = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pbc_pkg::THR_W-1:0]         i_cfg_wdata,      // beat_threshold
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [pbc_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,   // sample_index, sample_value
    input  logic [pbc_pkg::IN_USER_W-1:0]     i_s_axis_tuser,   // clear_count
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [pbc_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata    // heart_value, beats_added,
                                                                // beat_total
);

    logic signed [pbc_pkg::THR_W-1:0]   r_thr;
    logic                               r_s1_vld;
    pbc_pkg::t_item                     r_s1;
    logic                               r_out_vld;
    logic signed [pbc_pkg::HEART_W-1:0] r_out_heart;
    logic [pbc_pkg::ADD_W-1:0]          r_out_added;
    logic [pbc_pkg::COUNT_W-1:0]        r_out_total;

    pbc_pkg::t_item                     n_item;
    logic                               adv;
    logic                               accept;
    logic [pbc_pkg::VAL_W-1:0]          mean;
    logic signed [pbc_pkg::HEART_W-1:0] n_heart;
    logic [pbc_pkg::ADD_W-1:0]          n_added;
    logic [pbc_pkg::COUNT_W-1:0]        n_total;

    // The word in the first register moves on whenever the output register
    // is empty or is being emptied in this cycle.
    assign adv             = r_s1_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_vld || adv;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign n_item.slot  = i_s_axis_tdata[pbc_pkg::IDX_W-1:0];
    assign n_item.value = i_s_axis_tdata[pbc_pkg::IDX_W +: pbc_pkg::VAL_W];
    assign n_item.clear = i_s_axis_tuser[0];

    pbc_window #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_slot (n_item.slot),
        .i_adv     (adv),
        .i_s1      (r_s1),
        .o_mean    (mean)
    );

    // Both operands fit in ten bits, so the difference always fits in eleven.
    assign n_heart = $signed({1'b0, r_s1.value}) - $signed({1'b0, mean});

    pbc_detect u_detect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_heart     (n_heart),
        .i_clear     (r_s1.clear),
        .i_threshold (r_thr),
        .o_added     (n_added),
        .o_total     (n_total)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_item;
        end
        if (adv) begin
            r_out_heart <= n_heart;
            r_out_added <= n_added;
            r_out_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= pbc_pkg::THR_RESET;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= $signed(i_cfg_wdata);
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{pbc_pkg::OUT_PAD_W{1'b0}}, r_out_total, r_out_added,
                              r_out_heart};

    `PBC_ASSERT_RST(a_reset_empties, !i_rst_n |=> (!r_s1_vld && !r_out_vld), "pipeline not empty after reset")
    `PBC_ASSERT(a_full_stall_refuses, (r_s1_vld && r_out_vld && !i_m_axis_tready) |-> !o_s_axis_tready, "word taken while both registers are full and stalled")

endmodule
